/* rtl/i2cm_pkg.sv */
// Package of the I2C master bit engine: beat structs, codes, phase enum.
// No dependencies; imported by every rtl module of the block.
package i2cm_pkg;

    localparam int TIMER_BITS = 16;
    localparam int HP_BITS    = 16;
    localparam int ADDR_BITS  = 3;

    typedef enum logic [2:0] {
        REQ_START   = 3'd0,
        REQ_STOP    = 3'd1,
        REQ_WRITE   = 3'd2,
        REQ_READ    = 3'd3,
        REQ_RDACK   = 3'd4,
        REQ_SENDACK = 3'd5,
        REQ_CHECK   = 3'd6,
        REQ_SENDCMD = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FAIL = 2'd1,
        ST_BUSY = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_ST_A = 4'd1,
        PH_ST_B = 4'd2,
        PH_SP_A = 4'd3,
        PH_SP_B = 4'd4,
        PH_WB_H = 4'd5,
        PH_WB_L = 4'd6,
        PH_RB_H = 4'd7,
        PH_RB_L = 4'd8,
        PH_RA_H = 4'd9,
        PH_SA_H = 4'd10
    } phase_t;

    // Register indexes on the configuration port
    typedef enum logic {
        REG_HALF_PERIOD   = 1'b0,
        REG_SLAVE_ADDRESS = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic        cmd_valid;
        req_t        req_type;
        logic [7:0]  write_data;
        logic [3:0]  bit_count;
        logic        with_start;
        logic        with_stop;
        logic        sda_in;
        logic        scl_in;
    } req_beat_t;

    typedef struct packed {
        logic        scl_out;
        logic        sda_out;
        logic        cmd_done;
        status_t     status;
        logic [7:0]  read_data;
        logic        ready_res;
    } res_beat_t;

    typedef struct packed {
        logic [HP_BITS-1:0] half_period;
        logic [7:0]         slave_address;
    } cfg_t;

endpackage

/* rtl/i2cm_cfg.sv */
// Configuration registers of the I2C master bit engine, APB-style write/read.
// Depends on i2cm_pkg.
module i2cm_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [i2cm_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output i2cm_pkg::cfg_t                 cfg
);
    import i2cm_pkg::*;

    logic [HP_BITS-1:0] half_period_reg;
    logic [HP_BITS-1:0] half_period_next;
    logic [7:0]         slave_address_reg;
    logic [7:0]         slave_address_next;
    logic               wr_en;
    reg_idx_t           idx;

    assign wr_en = psel && penable && pwrite;
    assign idx   = reg_idx_t'(paddr[2]);

    always_comb
    begin
        half_period_next   = half_period_reg;
        slave_address_next = slave_address_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_HALF_PERIOD:   half_period_next   = pwdata[HP_BITS-1:0];
                REG_SLAVE_ADDRESS: slave_address_next = pwdata[7:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg   <= HP_BITS'(5);
            slave_address_reg <= 8'd0;
        end
        else
        begin
            half_period_reg   <= half_period_next;
            slave_address_reg <= slave_address_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_HALF_PERIOD:   prdata = 32'(half_period_reg);
            REG_SLAVE_ADDRESS: prdata = 32'(slave_address_reg);
        endcase
    end

    assign cfg.half_period   = half_period_reg;
    assign cfg.slave_address = slave_address_reg;

endmodule

/* rtl/i2cm_core.sv */
// Bus phase sequencer of the I2C master bit engine: state registers and the
// per-tick next-state logic. Depends on i2cm_pkg.
module i2cm_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  i2cm_pkg::req_beat_t req,
    input  i2cm_pkg::cfg_t      cfg,
    output i2cm_pkg::res_beat_t res
);
    import i2cm_pkg::*;

    phase_t                phase_reg,   phase_next;
    logic [TIMER_BITS-1:0] timer_reg,   timer_next;
    logic [3:0]            bits_reg,    bits_next;
    logic [7:0]            shift_reg,   shift_next;
    logic                  scl_reg,     scl_next;
    logic                  sda_reg,     sda_next;
    logic                  fstop_reg,   fstop_next;
    logic                  ffail_reg,   ffail_next;
    req_t                  cmd_reg,     cmd_next;
    logic                  done_next;
    status_t               status_next;
    logic [7:0]            rdata_next;
    logic [TIMER_BITS-1:0] hp;

    // Clamp the half period to the timer range and to at least one tick
    function automatic logic [TIMER_BITS-1:0] hold_ticks(logic [HP_BITS-1:0] v);
        logic [31:0] ext;
        logic [31:0] lim;
        ext = 32'(v);
        lim = 32'((64'd1 << TIMER_BITS) - 64'd1);
        if (ext > lim)
            ext = lim;
        if (ext == 32'd0)
            ext = 32'd1;
        return TIMER_BITS'(ext);
    endfunction

    function automatic logic [3:0] sat_count(logic [3:0] n);
        return (n > 4'd8) ? 4'd8 : n;
    endfunction

    assign hp = hold_ticks(cfg.half_period);

    // Next state for one tick
    always_comb
    begin
        logic [3:0] n;
        n           = 4'd0;
        phase_next  = phase_reg;
        timer_next  = timer_reg;
        bits_next   = bits_reg;
        shift_next  = shift_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        fstop_next  = fstop_reg;
        ffail_next  = ffail_reg;
        cmd_next    = cmd_reg;
        done_next   = 1'b0;
        status_next = ST_OK;
        rdata_next  = 8'd0;

        if (phase_reg == PH_IDLE)
        begin
            if (req.cmd_valid)
            begin
                cmd_next   = req.req_type;
                fstop_next = 1'b0;
                ffail_next = 1'b0;
                unique case (req.req_type)
                    REQ_START:
                    begin
                        phase_next = PH_ST_A; scl_next = 1'b1; sda_next = 1'b1;
                        timer_next = hp;
                    end
                    REQ_STOP:
                    begin
                        phase_next = PH_SP_A; scl_next = 1'b1; sda_next = 1'b0;
                        timer_next = hp;
                    end
                    REQ_WRITE:
                    begin
                        scl_next = 1'b0;
                        n = sat_count(req.bit_count);
                        if (n == 4'd0)
                        begin
                            phase_next = PH_IDLE; timer_next = '0; done_next = 1'b1;
                        end
                        else
                        begin
                            shift_next = 8'(req.write_data << (4'd8 - n));
                            bits_next  = n;
                            phase_next = PH_WB_H; scl_next = 1'b1;
                            sda_next   = shift_next[7];
                            timer_next = hp;
                        end
                    end
                    REQ_READ:
                    begin
                        scl_next = 1'b0; sda_next = 1'b1; shift_next = 8'd0;
                        n = sat_count(req.bit_count);
                        if (n == 4'd0)
                        begin
                            phase_next = PH_IDLE; timer_next = '0; done_next = 1'b1;
                        end
                        else
                        begin
                            bits_next  = n;
                            phase_next = PH_RB_H; scl_next = 1'b1;
                            timer_next = hp;
                        end
                    end
                    REQ_RDACK:
                    begin
                        phase_next = PH_RA_H; scl_next = 1'b1; sda_next = 1'b1;
                        timer_next = hp;
                    end
                    REQ_SENDACK:
                    begin
                        phase_next = PH_SA_H; scl_next = 1'b1;
                        sda_next = req.write_data[0]; timer_next = hp;
                    end
                    REQ_CHECK:
                    begin
                        if (req.scl_in && req.sda_in)
                        begin
                            shift_next = cfg.slave_address | 8'h01;
                            phase_next = PH_ST_A; scl_next = 1'b1; sda_next = 1'b1;
                            timer_next = hp;
                        end
                        else
                        begin
                            phase_next = PH_IDLE; timer_next = '0;
                            done_next = 1'b1; status_next = ST_BUSY;
                        end
                    end
                    REQ_SENDCMD:
                    begin
                        shift_next = req.write_data;
                        fstop_next = req.with_stop;
                        if (req.with_start)
                        begin
                            phase_next = PH_ST_A; scl_next = 1'b1; sda_next = 1'b1;
                        end
                        else
                        begin
                            bits_next  = 4'd8;
                            phase_next = PH_WB_H; scl_next = 1'b1;
                            sda_next   = req.write_data[7];
                        end
                        timer_next = hp;
                    end
                endcase
            end
        end
        else if (timer_reg > TIMER_BITS'(1))
        begin
            timer_next = timer_reg - TIMER_BITS'(1);
        end
        else
        begin
            unique case (phase_reg)
                PH_ST_A:
                begin
                    phase_next = PH_ST_B; scl_next = 1'b1; sda_next = 1'b0;
                    timer_next = hp;
                end
                PH_ST_B:
                begin
                    scl_next = 1'b0; sda_next = 1'b0;
                    if (cmd_reg == REQ_CHECK || (cmd_reg == REQ_SENDCMD && !req.sda_in))
                    begin
                        // address or command byte follows the start
                        bits_next  = 4'd8;
                        phase_next = PH_WB_H; scl_next = 1'b1;
                        sda_next   = shift_reg[7]; timer_next = hp;
                    end
                    else if (cmd_reg == REQ_SENDCMD)
                    begin
                        ffail_next = 1'b1;
                        phase_next = PH_SP_A; scl_next = 1'b1; sda_next = 1'b0;
                        timer_next = hp;
                    end
                    else
                    begin
                        phase_next = PH_IDLE; timer_next = '0; done_next = 1'b1;
                        status_next = req.sda_in ? ST_FAIL : ST_OK;
                    end
                end
                PH_SP_A:
                begin
                    phase_next = PH_SP_B; scl_next = 1'b1; sda_next = 1'b1;
                    timer_next = hp;
                end
                PH_SP_B:
                begin
                    phase_next = PH_IDLE; timer_next = '0; done_next = 1'b1;
                    if (cmd_reg == REQ_SENDCMD)
                        status_next = ffail_reg ? ST_FAIL : ST_OK;
                    else
                        status_next = req.sda_in ? ST_OK : ST_FAIL;
                end
                PH_WB_H:
                begin
                    phase_next = PH_WB_L; scl_next = 1'b0; timer_next = hp;
                end
                PH_WB_L:
                begin
                    shift_next = {shift_reg[6:0], 1'b0};
                    bits_next  = (bits_reg > 4'd0) ? bits_reg - 4'd1 : bits_reg;
                    if (bits_next > 4'd0)
                    begin
                        phase_next = PH_WB_H; scl_next = 1'b1;
                        sda_next = shift_next[7]; timer_next = hp;
                    end
                    else if (cmd_reg == REQ_CHECK || cmd_reg == REQ_SENDCMD)
                    begin
                        phase_next = PH_RA_H; scl_next = 1'b1; sda_next = 1'b1;
                        timer_next = hp;
                    end
                    else
                    begin
                        phase_next = PH_IDLE; timer_next = '0; done_next = 1'b1;
                    end
                end
                PH_RB_H:
                begin
                    shift_next = {shift_reg[6:0], req.sda_in};
                    phase_next = PH_RB_L; scl_next = 1'b0; sda_next = 1'b1;
                    timer_next = hp;
                end
                PH_RB_L:
                begin
                    bits_next = (bits_reg > 4'd0) ? bits_reg - 4'd1 : bits_reg;
                    if (bits_next > 4'd0)
                    begin
                        phase_next = PH_RB_H; scl_next = 1'b1; sda_next = 1'b1;
                        timer_next = hp;
                    end
                    else
                    begin
                        phase_next = PH_IDLE; timer_next = '0; done_next = 1'b1;
                        rdata_next = shift_reg;
                    end
                end
                PH_RA_H:
                begin
                    scl_next = 1'b0; sda_next = 1'b1;
                    if (cmd_reg == REQ_SENDCMD && (req.sda_in || fstop_reg))
                    begin
                        // nack or requested stop closes the transfer
                        if (req.sda_in)
                            ffail_next = 1'b1;
                        phase_next = PH_SP_A; scl_next = 1'b1; sda_next = 1'b0;
                        timer_next = hp;
                    end
                    else
                    begin
                        phase_next = PH_IDLE; timer_next = '0; done_next = 1'b1;
                        if (cmd_reg != REQ_SENDCMD)
                            status_next = req.sda_in ? ST_FAIL : ST_OK;
                        if (cmd_reg != REQ_SENDCMD && cmd_reg != REQ_CHECK)
                            rdata_next = {7'd0, req.sda_in};
                    end
                end
                PH_SA_H:
                begin
                    scl_next = 1'b0;
                    phase_next = PH_IDLE; timer_next = '0; done_next = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE; timer_next = '0;
                end
            endcase
        end
    end

    // Result beat of this tick
    always_comb
    begin
        res.scl_out   = scl_next;
        res.sda_out   = sda_next;
        res.cmd_done  = done_next;
        res.status    = status_next;
        res.read_data = rdata_next;
        res.ready_res = (phase_next == PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            timer_reg <= '0;
            bits_reg  <= 4'd0;
            shift_reg <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            fstop_reg <= 1'b0;
            ffail_reg <= 1'b0;
            cmd_reg   <= REQ_START;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            timer_reg <= timer_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            fstop_reg <= fstop_next;
            ffail_reg <= ffail_next;
            cmd_reg   <= cmd_next;
        end
    end

endmodule

/* rtl/i2c_master_bit_engine_top.sv */
// Top level of the I2C master bit engine: config port, sequencer, result register.
// Depends on i2cm_pkg, i2cm_cfg and i2cm_core.
//
// Each request beat is one tick of the bus timer and yields exactly one result beat
// carrying the SCL/SDA drive levels, the completion flag, status and read data. The
// block takes one beat per clock cycle; the sequencer works out the next phase in the
// same cycle and the result lands in a one-deep output register in the cycle after.
// The request side stalls only when that register holds a beat and the result side
// stalls it. All bus timing (half_period ticks per phase, minimum one) counts beats,
// not clock cycles. Commands offered while a command is in progress are ignored;
// watch ready_res. Write configuration only while the engine is idle.
module i2c_master_bit_engine_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  i2cm_pkg::req_beat_t            req_beat,
    output logic                           res_valid,
    input  logic                           res_stall,
    output i2cm_pkg::res_beat_t            res_beat,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [i2cm_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import i2cm_pkg::*;

    cfg_t      cfg;
    res_beat_t core_res;
    logic      accept;
    logic      res_valid_reg, res_valid_next;
    res_beat_t res_beat_reg;

    assign pready = 1'b1;

    i2cm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Hold request beats only while a finished result waits on a stalled sink
    assign req_stall = res_valid_reg && res_stall;
    assign accept    = req_valid && !req_stall;

    i2cm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .req    (req_beat),
        .cfg    (cfg),
        .res    (core_res)
    );

    // Load a new result on every accepted beat, drop the old one once taken
    always_comb
    begin
        if (accept)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_beat_reg <= core_res;
    end

    assign res_valid = res_valid_reg;
    assign res_beat  = res_beat_reg;

`ifndef SYNTHESIS
    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid_reg)
        else $error("accepted beat produced no result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_beat_reg.cmd_done) |-> res_beat_reg.ready_res)
        else $error("completion reported while engine not idle");

    a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_beat_reg.status != ST_OK) |-> res_beat_reg.cmd_done)
        else $error("status reported without completion");

    a_data_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_beat_reg.read_data != 8'd0) |-> res_beat_reg.cmd_done)
        else $error("read data reported without completion");
`endif

endmodule

/* dv/i2c_bus_checker.sv */
`timescale 1ns / 1ps
// Checker of the I2C master bit engine: watches both beat channels and the config port.
// Predicts every result beat from its own copy of the engine and compares; uses i2cm_pkg.
module i2c_bus_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    input  logic                           req_stall,
    input  i2cm_pkg::req_beat_t            req_beat,
    input  logic                           res_valid,
    input  logic                           res_stall,
    input  i2cm_pkg::res_beat_t            res_beat,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [i2cm_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                    pwdata,
    input  logic                           pready,
    input  logic                           run_over,
    output int                             fault_cnt
);
    import i2cm_pkg::*;

    // configuration copy
    logic [15:0] cfg_half;
    logic [7:0]  cfg_addr;

    // engine copy
    phase_t      ph;
    int unsigned hold_cnt;
    int unsigned bits_left;
    logic [7:0]  shreg;
    logic        drv_scl;
    logic        drv_sda;
    logic        want_stop;
    logic        saw_fail;
    req_t        cur_req;

    // completion of the current tick
    logic        tick_done;
    status_t     tick_status;
    logic [7:0]  tick_data;

    res_beat_t   bus_results_due[$];
    res_beat_t   oldest;
    logic        closed;
    int          faults;

    assign fault_cnt = faults;

    function automatic int unsigned phase_len();
        return (cfg_half == 16'd0) ? 1 : int'(cfg_half);
    endfunction

    function automatic void enter(input phase_t p, input logic scl, input logic sda);
        ph       = p;
        drv_scl  = scl;
        drv_sda  = sda;
        hold_cnt = phase_len();
    endfunction

    function automatic void complete(input status_t st, input logic [7:0] d);
        ph          = PH_IDLE;
        hold_cnt    = 0;
        tick_done   = 1'b1;
        tick_status = st;
        tick_data   = d;
    endfunction

    function automatic void begin_start();
        enter(PH_ST_A, 1'b1, 1'b1);
    endfunction

    function automatic void begin_stop();
        enter(PH_SP_A, 1'b1, 1'b0);
    endfunction

    function automatic void begin_ackread();
        enter(PH_RA_H, 1'b1, 1'b1);
    endfunction

    function automatic void bits_written();
        if (cur_req == REQ_CHECK || cur_req == REQ_SENDCMD)
            begin_ackread();
        else
            complete(ST_OK, 8'd0);
    endfunction

    function automatic void begin_write(input int unsigned n, input logic [7:0] d);
        drv_scl = 1'b0;
        if (n > 8) n = 8;
        if (n == 0)
        begin
            bits_written();
            return;
        end
        shreg     = 8'(d << (8 - n));
        bits_left = n;
        enter(PH_WB_H, 1'b1, shreg[7]);
    endfunction

    function automatic void begin_read(input int unsigned n);
        drv_scl = 1'b0;
        drv_sda = 1'b1;
        if (n > 8) n = 8;
        shreg = 8'd0;
        if (n == 0)
        begin
            complete(ST_OK, shreg);
            return;
        end
        bits_left = n;
        enter(PH_RB_H, 1'b1, 1'b1);
    endfunction

    function automatic void start_over(input logic fail);
        if (cur_req == REQ_CHECK)
            begin_write(8, shreg);
        else if (cur_req == REQ_SENDCMD)
        begin
            if (fail)
            begin
                saw_fail = 1'b1;
                begin_stop();
            end
            else
                begin_write(8, shreg);
        end
        else
            complete(fail ? ST_FAIL : ST_OK, 8'd0);
    endfunction

    function automatic void stop_over(input logic fail);
        if (cur_req == REQ_SENDCMD)
            complete(saw_fail ? ST_FAIL : ST_OK, 8'd0);
        else
            complete(fail ? ST_FAIL : ST_OK, 8'd0);
    endfunction

    function automatic void ack_over(input logic nack);
        if (cur_req == REQ_SENDCMD)
        begin
            if (nack) saw_fail = 1'b1;
            if (nack || want_stop)
                begin_stop();
            else
                complete(ST_OK, 8'd0);
        end
        else if (cur_req == REQ_CHECK)
            complete(nack ? ST_FAIL : ST_OK, 8'd0);
        else
            complete(nack ? ST_FAIL : ST_OK, {7'd0, nack});
    endfunction

    function automatic void phase_over(input logic sda);
        case (ph)
            PH_ST_A: enter(PH_ST_B, 1'b1, 1'b0);
            PH_ST_B:
            begin
                drv_scl = 1'b0;
                drv_sda = 1'b0;
                start_over(sda);
            end
            PH_SP_A: enter(PH_SP_B, 1'b1, 1'b1);
            PH_SP_B: stop_over(!sda);
            PH_WB_H: enter(PH_WB_L, 1'b0, drv_sda);
            PH_WB_L:
            begin
                shreg = {shreg[6:0], 1'b0};
                if (bits_left > 0) bits_left--;
                if (bits_left > 0)
                    enter(PH_WB_H, 1'b1, shreg[7]);
                else
                    bits_written();
            end
            PH_RB_H:
            begin
                shreg = {shreg[6:0], sda};
                enter(PH_RB_L, 1'b0, 1'b1);
            end
            PH_RB_L:
            begin
                if (bits_left > 0) bits_left--;
                if (bits_left > 0)
                    enter(PH_RB_H, 1'b1, 1'b1);
                else
                    complete(ST_OK, shreg);
            end
            PH_RA_H:
            begin
                drv_scl = 1'b0;
                drv_sda = 1'b1;
                ack_over(sda);
            end
            PH_SA_H:
            begin
                drv_scl = 1'b0;
                complete(ST_OK, 8'd0);
            end
            default:
            begin
                ph       = PH_IDLE;
                hold_cnt = 0;
            end
        endcase
    endfunction

    function automatic void take_command(input req_beat_t b);
        cur_req   = b.req_type;
        want_stop = 1'b0;
        saw_fail  = 1'b0;
        case (b.req_type)
            REQ_START:   begin_start();
            REQ_STOP:    begin_stop();
            REQ_WRITE:   begin_write(b.bit_count, b.write_data);
            REQ_READ:    begin_read(b.bit_count);
            REQ_RDACK:   begin_ackread();
            REQ_SENDACK: enter(PH_SA_H, 1'b1, b.write_data[0]);
            REQ_CHECK:
            begin
                if (b.scl_in && b.sda_in)
                begin
                    shreg = cfg_addr | 8'h01;
                    begin_start();
                end
                else
                    complete(ST_BUSY, 8'd0);
            end
            default:
            begin
                shreg     = b.write_data;
                want_stop = b.with_stop;
                if (b.with_start)
                    begin_start();
                else
                    begin_write(8, b.write_data);
            end
        endcase
    endfunction

    // One bus tick: advance the engine copy and form the result beat it should give.
    function automatic res_beat_t advance_engine(input req_beat_t b);
        res_beat_t r;
        tick_done   = 1'b0;
        tick_status = ST_OK;
        tick_data   = 8'd0;
        if (ph == PH_IDLE)
        begin
            if (b.cmd_valid) take_command(b);
        end
        else if (hold_cnt > 1)
            hold_cnt--;
        else
            phase_over(b.sda_in);
        r.scl_out   = drv_scl;
        r.sda_out   = drv_sda;
        r.cmd_done  = tick_done;
        r.status    = tick_status;
        r.read_data = tick_data;
        r.ready_res = (ph == PH_IDLE);
        return r;
    endfunction

    task automatic compare_field(input string fname, input int want, input int seen);
        if (want != seen)
        begin
            faults++;
            if (faults <= 30)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, seen);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_half  = 16'd5;
            cfg_addr  = 8'd0;
            ph        = PH_IDLE;
            hold_cnt  = 0;
            bits_left = 0;
            shreg     = 8'd0;
            drv_scl   = 1'b1;
            drv_sda   = 1'b1;
            want_stop = 1'b0;
            saw_fail  = 1'b0;
            cur_req   = REQ_START;
            closed    = 1'b0;
            bus_results_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[ADDR_BITS-1:2]))
                    REG_HALF_PERIOD:   cfg_half = pwdata[15:0];
                    REG_SLAVE_ADDRESS: cfg_addr = pwdata[7:0];
                    default: ;
                endcase
            end
            // compare before pushing, so a beat never matches its own prediction
            if (res_valid && !res_stall)
            begin
                if (bus_results_due.size() == 0)
                begin
                    faults++;
                    if (faults <= 30)
                        $display("%0t: result beat with nothing expected, actual %h",
                                 $time, res_beat);
                end
                else
                begin
                    oldest = bus_results_due.pop_front();
                    compare_field("scl_out", oldest.scl_out, res_beat.scl_out);
                    compare_field("sda_out", oldest.sda_out, res_beat.sda_out);
                    compare_field("cmd_done", oldest.cmd_done, res_beat.cmd_done);
                    compare_field("status", int'(oldest.status), int'(res_beat.status));
                    compare_field("read_data", oldest.read_data, res_beat.read_data);
                    compare_field("ready_res", oldest.ready_res, res_beat.ready_res);
                end
            end
            if (req_valid && !req_stall)
                bus_results_due.push_back(advance_engine(req_beat));
            if (run_over && !closed)
            begin
                closed = 1'b1;
                if (bus_results_due.size() != 0)
                begin
                    faults++;
                    $display("%0t: %0d result beats expected but never arrived, expected 0",
                             $time, bus_results_due.size());
                end
            end
        end
    end

    initial faults = 0;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench top of the I2C master bit engine: clock, reset, stimulus, verdict.
// Depends on i2cm_pkg, i2c_master_bit_engine_top and i2c_bus_checker.
module tb_top;
    import i2cm_pkg::*;

    // Safety net: the slowest legal run ends well before this limit.
    localparam int LIMIT = 1000000;

    logic                 clk;
    logic                 rst_n;
    logic                 req_valid;
    logic                 req_stall;
    req_beat_t            req_beat;
    logic                 res_valid;
    logic                 res_stall;
    res_beat_t            res_beat;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 run_over;
    int                   fault_cnt;

    // flow-control mix of the current phase, in percent
    int snd_idle_pct;
    int rcv_stall_pct;

    // beat bookkeeping: sent by the stimulus, seen on the result side
    int   ticks_sent;
    int   ticks_seen;
    int   cmds_done;
    logic engine_idle;
    int   cycle_cnt;

    i2c_master_bit_engine_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_beat  (req_beat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    i2c_bus_checker u_bus_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_beat  (req_beat),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_beat  (res_beat),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .run_over  (run_over),
        .fault_cnt (fault_cnt)
    );

    always #1 clk = ~clk;

    // Stall the result side at the rate of the current phase.
    always @(posedge clk)
        res_stall <= ($urandom_range(99) < rcv_stall_pct);

    // Track accepted result beats; ready_res of the latest one tells whether the
    // engine sat idle after that tick.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_seen  <= 0;
            cmds_done   <= 0;
            engine_idle <= 1'b1;
        end
        else if (res_valid && !res_stall)
        begin
            ticks_seen  <= ticks_seen + 1;
            cmds_done   <= cmds_done + res_beat.cmd_done;
            engine_idle <= res_beat.ready_res;
        end
    end

    // Stop a hung run.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Drop valid for one cycle.
    task automatic pause();
        req_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offer one beat, with random sender gaps ahead of it, and hold it until taken.
    task automatic send_beat(input req_beat_t b);
        while ($urandom_range(99) < snd_idle_pct)
            pause();
        req_beat  <= b;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        ticks_sent++;
    endtask

    // Hold off the sender until every beat sent has come back.
    task automatic drain();
        do
            pause();
        while (ticks_sent != ticks_seen);
    endtask

    function automatic logic [3:0] pick_count();
        // mostly legal counts; now and then zero or above eight
        if ($urandom_range(9) == 0)
            return 4'($urandom_range(15));
        return 4'($urandom_range(8, 1));
    endfunction

    // One bus tick: SDA high with the given odds, SCL mostly released, and a
    // command offered with the given odds (ignored while the engine is busy).
    function automatic req_beat_t line_tick(input int sda_pct, input int cmd_pct);
        req_beat_t b;
        b.cmd_valid  = ($urandom_range(99) < cmd_pct);
        b.req_type   = req_t'($urandom_range(7));
        b.write_data = 8'($urandom);
        b.bit_count  = pick_count();
        b.with_start = 1'($urandom);
        b.with_stop  = 1'($urandom);
        b.sda_in     = ($urandom_range(99) < sda_pct);
        b.scl_in     = ($urandom_range(99) < 85);
        return b;
    endfunction

    function automatic req_beat_t mk(input req_t t, input logic [7:0] d, input logic [3:0] n,
                                     input logic ws, input logic wp,
                                     input logic sda, input logic scl);
        req_beat_t b;
        b.cmd_valid  = 1'b1;
        b.req_type   = t;
        b.write_data = d;
        b.bit_count  = n;
        b.with_start = ws;
        b.with_stop  = wp;
        b.sda_in     = sda;
        b.scl_in     = scl;
        return b;
    endfunction

    // Advance ticks until the engine is idle and nothing is in flight. Keep sending
    // while the latest result says busy; once it says idle, just let the rest drain.
    task automatic wait_idle(input int sda_pct, input int cmd_pct);
        while (!(ticks_sent == ticks_seen && engine_idle))
        begin
            if (engine_idle)
                pause();
            else
                send_beat(line_tick(sda_pct, cmd_pct));
        end
    endtask

    task automatic cfg_write(input reg_idx_t idx, input logic [31:0] val);
        logic [ADDR_BITS-1:0] a;
        a = '0;
        a[ADDR_BITS-1:2] = idx;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Offer a directed command on an idle engine and run it to completion.
    task automatic run_cmd(input req_beat_t b, input int sda_pct, input int cmd_pct);
        send_beat(b);
        wait_idle(sda_pct, cmd_pct);
    endtask

    // Random bus traffic. SDA odds drift between mostly low, even and mostly high
    // so starts, acks and stops both pass and fail in runs.
    task automatic random_ticks(input int n);
        int sda_bias;
        int bias_left;
        sda_bias  = 50;
        bias_left = 0;
        for (int i = 0; i < n; i++)
        begin
            if (bias_left == 0)
            begin
                case ($urandom_range(2))
                    0:       sda_bias = 10;
                    1:       sda_bias = 50;
                    default: sda_bias = 90;
                endcase
                bias_left = $urandom_range(64, 16);
            end
            bias_left--;
            if ($urandom_range(199) == 0)
                drain();
            send_beat(line_tick(sda_bias, 25));
        end
        wait_idle(50, 0);
    endtask

    // Set the flow-control mix, reprogram while idle, then run random traffic.
    task automatic run_phase(input int snd, input int rcv, input logic [15:0] hp,
                             input logic [7:0] addr, input int n);
        snd_idle_pct  = snd;
        rcv_stall_pct = rcv;
        cfg_write(REG_HALF_PERIOD, {16'd0, hp});
        cfg_write(REG_SLAVE_ADDRESS, {24'd0, addr});
        random_ticks(n);
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req_beat      = '0;
        res_stall     = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        run_over      = 1'b0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        ticks_sent    = 0;
        cycle_cnt     = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed commands at the reset settings (half period 5, address 0).
        // Start: SDA held low passes, SDA left high fails.
        run_cmd(mk(REQ_START, 8'h00, 4'd0, 1'b0, 1'b0, 1'b1, 1'b1), 0, 0);
        run_cmd(mk(REQ_START, 8'hFF, 4'd15, 1'b1, 1'b1, 1'b0, 1'b0), 100, 0);
        // Stop: SDA released passes, SDA stuck low fails.
        run_cmd(mk(REQ_STOP, 8'h00, 4'd0, 1'b0, 1'b0, 1'b1, 1'b1), 100, 0);
        run_cmd(mk(REQ_STOP, 8'hFF, 4'd8, 1'b1, 1'b1, 1'b0, 1'b1), 0, 0);
        // Writes: full byte of ones, one bit of zero, zero bits, count saturated.
        run_cmd(mk(REQ_WRITE, 8'hFF, 4'd8, 1'b0, 1'b0, 1'b1, 1'b1), 50, 0);
        run_cmd(mk(REQ_WRITE, 8'h00, 4'd1, 1'b1, 1'b1, 1'b0, 1'b0), 50, 0);
        run_cmd(mk(REQ_WRITE, 8'hA5, 4'd0, 1'b0, 1'b0, 1'b1, 1'b1), 50, 0);
        run_cmd(mk(REQ_WRITE, 8'h5A, 4'd15, 1'b0, 1'b1, 1'b0, 1'b1), 50, 0);
        // Reads: random byte, zero bits, saturated count on a released line.
        run_cmd(mk(REQ_READ, 8'h00, 4'd8, 1'b0, 1'b0, 1'b1, 1'b1), 50, 0);
        run_cmd(mk(REQ_READ, 8'hFF, 4'd0, 1'b1, 1'b1, 1'b1, 1'b1), 50, 0);
        run_cmd(mk(REQ_READ, 8'h00, 4'd9, 1'b0, 1'b0, 1'b1, 1'b1), 100, 0);
        // Ack read: ack then nack.
        run_cmd(mk(REQ_RDACK, 8'h00, 4'd1, 1'b0, 1'b0, 1'b0, 1'b1), 0, 0);
        run_cmd(mk(REQ_RDACK, 8'hFF, 4'd1, 1'b0, 1'b0, 1'b1, 1'b1), 100, 0);
        // Send ack, then send nack.
        run_cmd(mk(REQ_SENDACK, 8'hFE, 4'd1, 1'b0, 1'b0, 1'b1, 1'b1), 50, 0);
        run_cmd(mk(REQ_SENDACK, 8'h01, 4'd1, 1'b0, 1'b0, 1'b1, 1'b1), 50, 0);
        // Check device: SCL low or SDA low means busy; both high runs the probe.
        run_cmd(mk(REQ_CHECK, 8'h00, 4'd8, 1'b0, 1'b0, 1'b1, 1'b0), 50, 0);
        run_cmd(mk(REQ_CHECK, 8'h00, 4'd8, 1'b0, 1'b0, 1'b0, 1'b1), 50, 0);
        run_cmd(mk(REQ_CHECK, 8'h00, 4'd8, 1'b0, 1'b0, 1'b1, 1'b1), 0, 0);
        run_cmd(mk(REQ_CHECK, 8'hFF, 4'd8, 1'b1, 1'b1, 1'b1, 1'b1), 100, 0);
        // Send command: full path with stop, start failure, bare acked byte,
        // bare nacked byte (forces a stop).
        run_cmd(mk(REQ_SENDCMD, 8'hA0, 4'd0, 1'b1, 1'b1, 1'b1, 1'b1), 0, 0);
        run_cmd(mk(REQ_SENDCMD, 8'h3C, 4'd8, 1'b1, 1'b0, 1'b1, 1'b1), 100, 0);
        run_cmd(mk(REQ_SENDCMD, 8'hFF, 4'd8, 1'b0, 1'b0, 1'b0, 1'b0), 0, 0);
        run_cmd(mk(REQ_SENDCMD, 8'h00, 4'd15, 1'b0, 1'b0, 1'b1, 1'b1), 100, 0);
        // Commands offered while busy must be ignored.
        run_cmd(mk(REQ_WRITE, 8'hC3, 4'd8, 1'b0, 1'b0, 1'b1, 1'b1), 50, 30);

        // Random phases, each with its own flow-control mix and settings.
        run_phase(0, 0, 16'd1, 8'hFF, 150);
        run_phase(58, 0, 16'd0, 8'($urandom), 150);
        run_phase(0, 58, 16'd3, 8'h00, 150);
        run_phase(14, 14, 16'($urandom_range(6, 2)), 8'($urandom), 150);

        // Long half period: one single-phase command, no idling.
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        cfg_write(REG_HALF_PERIOD, 32'h0000_00A0);
        run_cmd(mk(REQ_SENDACK, 8'h01, 4'd1, 1'b0, 1'b0, 1'b1, 1'b1), 50, 0);

        // Let the pipeline settle, then close the books.
        repeat (8) @(posedge clk);
        run_over <= 1'b1;
        repeat (2) @(posedge clk);
        $display("Covered %0d bus ticks and %0d completed commands over half periods",
                 ticks_sent, cmds_done);
        $display("0 to 160 under four mixes of sender gaps and result stalls.");
        if (fault_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
